[hw/rtl/rls_pkg.sv]
// shared constants for the local semivariance block
// no dependencies
package rls_pkg;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [2:0] REG_ROW_COUNT    = 3'd0;
    localparam logic [2:0] REG_COLUMN_COUNT = 3'd1;
    localparam logic [2:0] REG_OFFSET_COUNT = 3'd2;
    localparam logic [2:0] REG_OFFSETS_LO   = 3'd3;
    localparam logic [2:0] REG_OFFSETS_HI   = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_MISSING = 2'd1;
    localparam logic [1:0] STATUS_NO_DIV  = 2'd2;

    localparam int SEMI_BITS  = 46;
    localparam int COUNT_BITS = 5;

    // raster side, fixed by the 8-bit row and column fields
    localparam int MAX_SIDE   = 256;

endpackage

[hw/rtl/raster_local_semivariance.sv]
// local semivariance over a raster held in one synchronous memory
// depends on rls_pkg
// Each accepted item is either a cell write (op 0, no result) or
// a compute (op 1, one result). A compute reads the centre cell, then walks
// the configured offsets one at a time through the single raster memory
// port (address, then registered read data), then squares each difference
// on a registered multiplier and finally divides the fixed point sum by
// twice (valid neighbours - 1) with a restoring divider that
// retires one quotient bit per cycle. A missing or out-of-range centre, or
// fewer than two valid neighbours, ends a compute early with a status and
// no division. The memory port and the serial divider set how long a
// compute takes. One item is in work at a time. The raster memory is not
// cleared; cells must be written before they are read. The result sits in
// an output register; the next item is accepted only once that result has
// been taken.
module raster_local_semivariance #(
    parameter int MAX_OFFSETS   = 16,
    parameter int VALUE_BITS    = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic [2:0]                    cfg_index,
    input  logic [63:0]                   cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [7:0]                    cell_row,
    input  logic [7:0]                    cell_column,
    input  logic signed [VALUE_BITS-1:0]  cell_value,
    input  logic                          cell_missing,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rls_pkg::SEMI_BITS-1:0] semivariance,
    output logic [1:0]                    status,
    output logic [rls_pkg::COUNT_BITS-1:0] valid_neighbours
);

    localparam int SIDE_BITS = $clog2(rls_pkg::MAX_SIDE);
    localparam int ADDR_BITS = 2 * SIDE_BITS;
    localparam int DEPTH     = rls_pkg::MAX_SIDE * rls_pkg::MAX_SIDE;
    localparam int DIFF_BITS = VALUE_BITS + 1;
    localparam int SQ_BITS   = 2 * VALUE_BITS;
    localparam int SUM_BITS  = SQ_BITS + 4;
    localparam int NUM_BITS  = SUM_BITS + FRACTION_BITS;
    localparam int DIV_BITS  = 6;
    localparam int CNT_BITS  = $clog2(NUM_BITS + 1);
    localparam int IDX_BITS  = 4;
    localparam int CRD_BITS  = 14;   // signed neighbour coordinate
    localparam int SEMI      = rls_pkg::SEMI_BITS;
    localparam int CB        = rls_pkg::COUNT_BITS;
    localparam logic [8:0] MAX_SIDE_9 = 9'(rls_pkg::MAX_SIDE);
    localparam logic [4:0] MAX_OFF_5  = 5'(MAX_OFFSETS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CWAIT = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // configuration registers
    logic [8:0]  row_count_reg;
    logic [8:0]  column_count_reg;
    logic [4:0]  offset_count_reg;
    logic [63:0] offsets_lo_reg;
    logic [63:0] offsets_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 9'd256;
            column_count_reg <= 9'd256;
            offset_count_reg <= 5'd9;
            offsets_lo_reg   <= '0;
            offsets_hi_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rls_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data[8:0];
                rls_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data[8:0];
                rls_pkg::REG_OFFSET_COUNT: offset_count_reg <= cfg_data[4:0];
                rls_pkg::REG_OFFSETS_LO:   offsets_lo_reg   <= cfg_data;
                rls_pkg::REG_OFFSETS_HI:   offsets_hi_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped sizes
    logic [8:0] rows, cols;
    logic [4:0] noff;
    assign rows = (row_count_reg > MAX_SIDE_9) ? MAX_SIDE_9 : row_count_reg;
    assign cols = (column_count_reg > MAX_SIDE_9) ? MAX_SIDE_9 : column_count_reg;
    assign noff = (offset_count_reg > MAX_OFF_5) ? MAX_OFF_5 : offset_count_reg;

    // raster memory: value plus missing mark, one port
    logic [VALUE_BITS:0] raster_mem [DEPTH];
    logic [VALUE_BITS:0] rd_data_reg;
    logic                mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [VALUE_BITS:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            raster_mem[mem_addr] <= mem_wdata;
        rd_data_reg <= raster_mem[mem_addr];
    end

    // control and datapath registers
    logic [2:0]            state_reg, state_next;
    logic [7:0]            crow_reg, ccol_reg;
    logic signed [VALUE_BITS-1:0] centre_reg;
    logic [IDX_BITS:0]     idx_reg;
    logic                  hit_reg;      // offset in range, read pending
    logic [SUM_BITS-1:0]   sum_reg;
    logic [CB-1:0]         cnt_reg;      // q + 1
    logic [SQ_BITS-1:0]    sq_reg;
    logic                  sq_valid_reg;
    logic [NUM_BITS-1:0]   num_reg;
    logic [NUM_BITS-1:0]   quo_reg;
    logic [DIV_BITS-1:0]   rem_reg;
    logic [DIV_BITS-1:0]   div_reg;
    logic [CNT_BITS-1:0]   bit_reg;
    logic                  out_valid_reg;
    logic [SEMI-1:0]       semi_reg;
    logic [1:0]            status_reg;
    logic [CB-1:0]         nb_reg;

    logic accept;
    assign in_ready = (state_reg == S_IDLE) && !(out_valid_reg && !out_ready);
    assign accept   = in_valid && in_ready;

    // current offset decode
    logic [7:0]  off_byte;
    logic [63:0] off_word;
    logic signed [CRD_BITS-1:0] nr, nc;
    logic        in_range;
    assign off_word = idx_reg[3] ? offsets_hi_reg : offsets_lo_reg;
    assign off_byte = off_word[idx_reg[2:0]*8 +: 8];
    assign nr = $signed({6'd0, crow_reg}) + CRD_BITS'($signed(off_byte[7:4]));
    assign nc = $signed({6'd0, ccol_reg}) + CRD_BITS'($signed(off_byte[3:0]));
    assign in_range = !nr[CRD_BITS-1] && !nc[CRD_BITS-1]
                   && (nr < $signed({5'd0, rows})) && (nc < $signed({5'd0, cols}));

    // memory port mux
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = {cell_missing, cell_value};
        mem_addr  = ADDR_BITS'({cell_row, ccol_reg});
        if (state_reg == S_IDLE)
        begin
            mem_addr = ADDR_BITS'({SIDE_BITS'(cell_row), SIDE_BITS'(cell_column)});
            mem_we   = accept && (op == rls_pkg::OP_WRITE);
        end
        else
            mem_addr = ADDR_BITS'({SIDE_BITS'(nr[7:0]), SIDE_BITS'(nc[7:0])});
    end

    // difference of centre and neighbour
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]        adiff;
    assign diff  = DIFF_BITS'(centre_reg) - DIFF_BITS'($signed(rd_data_reg[VALUE_BITS-1:0]));
    assign adiff = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);

    // divider step
    logic [DIV_BITS:0] rem_shift;
    logic              rem_ge;
    assign rem_shift = {rem_reg, num_reg[NUM_BITS-1]};
    assign rem_ge    = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept && op == rls_pkg::OP_COMPUTE) state_next = S_CWAIT;
            S_CWAIT: state_next = S_ADDR;
            S_ADDR:  if (idx_reg == IDX_BITS'(0) + (IDX_BITS+1)'(noff)) state_next = S_SQ;
                     else state_next = S_READ;
            S_READ:  state_next = S_ADDR;
            S_SQ:    state_next = S_DIV;
            S_DIV:   if (bit_reg == '0) state_next = S_DONE;
            S_DONE:  if (!(out_valid_reg && !out_ready)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && op == rls_pkg::OP_COMPUTE)
                    begin
                        crow_reg <= cell_row;
                        ccol_reg <= cell_column;
                        idx_reg  <= '0;
                        sum_reg  <= '0;
                        cnt_reg  <= '0;
                        hit_reg  <= 1'b0;
                        sq_valid_reg <= 1'b0;
                    end
                    state_reg <= state_next;
                end
                S_CWAIT:
                begin
                    centre_reg <= $signed(rd_data_reg[VALUE_BITS-1:0]);
                    if ({1'b0, crow_reg} >= rows || {1'b0, ccol_reg} >= cols
                        || rd_data_reg[VALUE_BITS])
                    begin
                        semi_reg      <= '0;
                        status_reg    <= rls_pkg::STATUS_MISSING;
                        nb_reg        <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    // retire last square
                    if (sq_valid_reg)
                        sum_reg <= sum_reg + SUM_BITS'(sq_reg);
                    sq_valid_reg <= 1'b0;
                    hit_reg <= in_range && (idx_reg != (IDX_BITS+1)'(noff));
                    state_reg <= state_next;
                end
                S_READ:
                begin
                    if (hit_reg && !rd_data_reg[VALUE_BITS])
                    begin
                        sq_reg       <= SQ_BITS'(adiff * adiff);
                        sq_valid_reg <= 1'b1;
                        cnt_reg      <= cnt_reg + CB'(1);
                    end
                    idx_reg   <= idx_reg + (IDX_BITS+1)'(1);
                    state_reg <= S_ADDR;
                end
                S_SQ:
                begin
                    // divisor is 2*q, numerator is sum with fraction bits
                    num_reg   <= NUM_BITS'(sum_reg) << FRACTION_BITS;
                    div_reg   <= DIV_BITS'({cnt_reg - CB'(1), 1'b0});
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    bit_reg   <= CNT_BITS'(NUM_BITS);
                    if (cnt_reg <= CB'(1))
                    begin
                        semi_reg      <= '0;
                        status_reg    <= rls_pkg::STATUS_NO_DIV;
                        nb_reg        <= cnt_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (bit_reg != '0)
                    begin
                        rem_reg <= rem_ge ? DIV_BITS'(rem_shift - {1'b0, div_reg})
                                          : DIV_BITS'(rem_shift);
                        quo_reg <= {quo_reg[NUM_BITS-2:0], rem_ge};
                        num_reg <= {num_reg[NUM_BITS-2:0], 1'b0};
                        bit_reg <= bit_reg - CNT_BITS'(1);
                    end
                    state_reg <= state_next;
                end
                S_DONE:
                begin
                    if (!(out_valid_reg && !out_ready))
                    begin
                        if (NUM_BITS > SEMI && (quo_reg >> SEMI) != '0)
                            semi_reg <= '1;
                        else
                            semi_reg <= SEMI'(quo_reg);
                        status_reg    <= rls_pkg::STATUS_OK;
                        nb_reg        <= cnt_reg;
                        out_valid_reg <= 1'b1;
                    end
                    state_reg <= state_next;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign semivariance     = semi_reg;
    assign status           = status_reg;
    assign valid_neighbours = nb_reg;

    // a result never starts while an undelivered one waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped");
    // compute never accepted outside idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    // valid count never exceeds offsets visited
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDR) |-> cnt_reg <= CB'(idx_reg))
        else $error("count overrun");

endmodule
